// ===== rtl/sltk_pkg.sv =====
// Shared types and constants for the sound level peak tracker.
package sltk_pkg;

	// Register map, indexed by paddr[2]
	typedef enum logic {
		REG_GAIN       = 1'b0,
		REG_PEAK_DELAY = 1'b1
	} reg_idx_t;

	localparam int PADDR_W = 3;
	localparam logic [15:0] GAIN_RESET = 16'd256;
	localparam logic [15:0] DELAY_RESET = 16'd100;
	localparam logic [7:0] FLOOR_RESET = 8'd255;

	// Sample scaling: level = adc * gain >> 18
	localparam int ADC_W = 10;
	localparam int GAIN_W = 16;
	localparam int PROD_W = ADC_W + GAIN_W;
	localparam int LEVEL_SHIFT = 18;

	// Item handed from the window stage to the floor/peak stage
	typedef struct packed {
		logic        valid;
		logic [7:0]  mean;
		logic [31:0] now_ms;
	} mean_item_t;

endpackage

// ===== rtl/sltk_hist_ram.sv =====
// History ring memory: one write and one registered read port, entries read zero until written.
module sltk_hist_ram import sltk_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int AW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rd_q;
	logic             rd_valid_q;
	logic [DEPTH-1:0] vld_q;
	logic             same_addr;

	// write-to-read bypass when both hit one entry in the same cycle
	assign same_addr = wr_en && (wr_addr == rd_addr);

	// storage and read register
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			if (same_addr)
				rd_q <= wr_data;
			else
				rd_q <= mem[rd_addr];
		end
	end

	// per-entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_valid_q <= same_addr || vld_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : 8'd0;

endmodule

// ===== rtl/sltk_window.sv =====
// Sample scaling, history ring update, running sum and window mean.
module sltk_window import sltk_pkg::*; #(
	parameter int HIST_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ADC_W-1:0]  adc_sample,
	input  logic [31:0]       now_ms,
	input  logic [GAIN_W-1:0] gain,
	input  logic              ready,
	output mean_item_t        item
);

	localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int SUM_MAX = 255 * HIST_DEPTH;
	localparam int SUM_W = $clog2(SUM_MAX + 1);
	localparam int DIV_L = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 0;
	localparam int DIV_S = SUM_W + DIV_L;
	localparam int MUL_W = SUM_W + 2;
	localparam int QP_W = SUM_W + MUL_W;
	localparam longint unsigned DivM = ((64'd1 << DIV_S) + HIST_DEPTH - 1) / HIST_DEPTH;
	localparam logic [MUL_W-1:0] DIV_M = MUL_W'(DivM);
	localparam logic [AW-1:0] LAST_POS = AW'(HIST_DEPTH - 1);

	logic [AW-1:0]       pos_q;
	logic                in_fire;
	logic                en_s1, en_s2, en_s3;
	logic                valid_s1, valid_s2, valid_s3;
	logic [PROD_W-1:0]   prod_s1;
	logic [31:0]         now_s1, now_s2, now_s3;
	logic [AW-1:0]       addr_s1;
	logic [7:0]          old_lvl;
	logic [7:0]          new_lvl;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_s2;
	logic [QP_W-1:0]     quot_prod;
	logic [7:0]          mean_s3;
	logic                adv_s1;

	// stage enables: a stage moves when the one after it is empty or moving
	assign en_s3    = !valid_s3 || ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign in_fire  = in_valid && en_s1;
	assign adv_s1   = valid_s1 && en_s2;

	// 10x16 product fits in 26 bits, so the shifted level never exceeds 255
	assign new_lvl = prod_s1[LEVEL_SHIFT +: 8];

	sltk_hist_ram #(
		.DEPTH(HIST_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (adv_s1),
		.wr_addr(addr_s1),
		.wr_data(new_lvl),
		.rd_en  (in_fire),
		.rd_addr(pos_q),
		.rd_data(old_lvl)
	);

	// mean by reciprocal multiply, exact for every sum below 2^SUM_W
	assign quot_prod = QP_W'(sum_s2) * QP_W'(DIV_M);

	// control: ring pointer, running sum, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_fire)
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
			if (adv_s1)
				sum_q <= sum_q - SUM_W'(old_lvl) + SUM_W'(new_lvl);
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_s1 <= PROD_W'(adc_sample) * PROD_W'(gain);
			now_s1  <= now_ms;
			addr_s1 <= pos_q;
		end
		if (adv_s1) begin
			sum_s2 <= sum_q;
			now_s2 <= now_s1;
		end
		if (valid_s2 && en_s3) begin
			mean_s3 <= 8'(quot_prod >> DIV_S);
			now_s3  <= now_s2;
		end
	end

	assign item.valid  = valid_s3;
	assign item.mean   = mean_s3;
	assign item.now_ms = now_s3;

`ifndef SYNTH
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(SUM_MAX))
		else $error("history sum above window maximum");
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("ring pointer beyond history depth");
`endif

endmodule

// ===== rtl/sltk_peak.sv =====
// Noise floor tracking, peak capture with hold and decay, output register.
module sltk_peak import sltk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mean_item_t        item,
	output logic              ready,
	input  logic [15:0]       peak_delay_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [8:0] level,
	output logic [7:0]        peak,
	output logic [7:0]        noise_floor
);

	logic              take;
	logic [7:0]        floor_q, floor_n;
	logic [7:0]        held_q, held_cap, held_n;
	logic [31:0]       stamp_q, stamp_n;
	logic signed [9:0] lvl_n;
	logic              capture;
	logic [31:0]       elapsed;
	logic              out_valid_q;
	logic signed [8:0] level_q;
	logic [7:0]        peak_q, floor_out_q;

	assign ready = !out_valid_q || !out_stall;
	assign take  = item.valid && ready;

	// floor steps down while above the mean; level is mean minus floor
	always_comb begin
		floor_n  = (floor_q > item.mean) ? floor_q - 8'd1 : floor_q;
		lvl_n    = $signed({2'b00, item.mean}) - $signed({2'b00, floor_n});
		capture  = lvl_n > $signed({2'b00, held_q});
		held_cap = capture ? lvl_n[7:0] : held_q;
		stamp_n  = capture ? item.now_ms : stamp_q;
		elapsed  = item.now_ms - stamp_n;
		held_n   = held_cap;
		if (held_cap != 8'd0 && elapsed >= {16'd0, peak_delay_ms})
			held_n = held_cap - 8'd1;
	end

	// tracker state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= FLOOR_RESET;
			held_q      <= '0;
			stamp_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				floor_q <= floor_n;
				held_q  <= held_n;
				stamp_q <= stamp_n;
			end
			if (ready)
				out_valid_q <= item.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			level_q     <= lvl_n[8:0];
			peak_q      <= held_n;
			floor_out_q <= floor_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign level       = level_q;
	assign peak        = peak_q;
	assign noise_floor = floor_out_q;

`ifndef SYNTH
	a_floor_down: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q <= $past(floor_q))
		else $error("noise floor rose");
	a_peak_vs_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !level_q[8] |-> ({1'b0, peak_q} + 9'd1) >= level_q[8:0])
		else $error("peak more than one below a positive level");
`endif

endmodule

// ===== rtl/sound_level_peak_tracker_top.sv =====
// Top level of the sound level peak tracker: register port and the two pipeline parts.
// One item per clock cycle while out_stall is low; a sample passes the scaling, sum, mean
// and output registers. The rate is set by the history ring memory and running sum:
// each cycle one history entry is read (registered) and one entry is written back while the
// sum updates by old-out/new-in. The mean then goes through a reciprocal multiply stage
// and the floor and peak update in the final stage, which also holds the output register.
// No clearing pass is needed after reset: unwritten history entries read as zero.
module sound_level_peak_tracker_top import sltk_pkg::*; #(
	parameter int WINDOW = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ADC_W-1:0]   adc_sample,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [8:0]  level,
	output logic [7:0]         peak,
	output logic [7:0]         noise_floor
);

	localparam int HIST_DEPTH = WINDOW - 1;

	logic [GAIN_W-1:0] gain_q;
	logic [15:0]       delay_q;
	reg_idx_t          reg_idx;
	logic              wr_fire;
	mean_item_t        item;
	logic              ready;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_fire = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			delay_q <= DELAY_RESET;
		end else if (wr_fire) begin
			unique case (reg_idx)
				REG_GAIN:       gain_q  <= pwdata[15:0];
				REG_PEAK_DELAY: delay_q <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_GAIN:       prdata = {16'd0, gain_q};
			REG_PEAK_DELAY: prdata = {16'd0, delay_q};
			default:        prdata = '0;
		endcase
	end

	sltk_window #(
		.HIST_DEPTH(HIST_DEPTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.adc_sample(adc_sample),
		.now_ms    (now_ms),
		.gain      (gain_q),
		.ready     (ready),
		.item      (item)
	);

	sltk_peak u_peak (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.ready        (ready),
		.peak_delay_ms(delay_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.level        (level),
		.peak         (peak),
		.noise_floor  (noise_floor)
	);

`ifndef SYNTH
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side can move");
`endif

endmodule
